### sv/scseg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scseg_pkg
// Shared widths, codes and controller/datapath interface types of the
// speech chunk segmenter.
// ----------------------------------------------------------------------------
package scseg_pkg;

    // Configuration register widths
    localparam int SR_W  = 18;
    localparam int FL_W  = 13;
    localparam int THR_W = 15;
    localparam int SEC_W = 10;
    localparam int GAP_W = 27;

    // Chunk state widths
    localparam int LEN_W   = 27;
    localparam int START_W = 48;
    localparam int SIL_W   = 32;

    // Result field widths
    localparam int START_MS_W = 46;
    localparam int DUR_MS_W   = 24;

    // Sample and energy widths
    localparam int SMP_W = 16;
    localparam int SQ_W  = 31;

    // Chunk start times 1000 stays below chunk start times 1024
    localparam int PROD_W = START_W + 10;
    // Seconds times sample rate
    localparam int LIM_W  = SEC_W + SR_W;

    // APB map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    // Input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_SAMPLE_RATE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_LEN     = 3'd1;
    localparam logic [IDX_W-1:0] REG_RMS_THRESHOLD = 3'd2;
    localparam logic [IDX_W-1:0] REG_MIN_CHUNK_SEC = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX_CHUNK_SEC = 3'd4;
    localparam logic [IDX_W-1:0] REG_GAP_SAMPLES   = 3'd5;

    // Register reset values
    localparam logic [SR_W-1:0]  RST_SAMPLE_RATE   = 18'd16000;
    localparam logic [FL_W-1:0]  RST_FRAME_LEN     = 13'd320;
    localparam logic [THR_W-1:0] RST_RMS_THRESHOLD = 15'd328;
    localparam logic [SEC_W-1:0] RST_MIN_CHUNK_SEC = 10'd5;
    localparam logic [SEC_W-1:0] RST_MAX_CHUNK_SEC = 10'd30;
    localparam logic [GAP_W-1:0] RST_GAP_SAMPLES   = 27'd8000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic in_load;    // capture the accepted request
        logic sq_load;    // square the sample, form the frame count
        logic acc;        // accumulate energy, form the threshold product
        logic frame_end;  // classify the frame and add it to the chunk
        logic flush_add;  // add the partial frame to the chunk
        logic mul_a;      // first partial of the times-1000 scaling
        logic mul_b;      // second partial of the times-1000 scaling
        logic sel_len;    // scale chunk length instead of chunk start
        logic div_start;  // launch the millisecond division
        logic out_load;   // load the result register and commit the chunk
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_flush;
        logic frame_done;
        logic chunk_empty;
        logic close_hit;
        logic div_done;
        logic out_full;
    } ctrl_stat_t;

endpackage

### sv/scseg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scseg_div
// Restoring divider, one quotient bit per cycle, for the millisecond
// conversion.
// ----------------------------------------------------------------------------
module scseg_div #(
    parameter int DVD_W = 58,
    parameter int DVS_W = 18
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic             qbit;

    // Shift one dividend bit into the remainder and try a subtract
    always_comb begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        qbit      = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = DVS_W'(trial - {1'b0, divisor});
                qbit     = 1'b1;
            end else begin
                rem_next = trial[DVS_W-1:0];
            end
            quo_next = {quo_reg[DVD_W-2:0], qbit};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Advance the working registers
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/scseg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scseg_dp
// Segmenter datapath: frame energy, chunk bookkeeping, millisecond
// conversion and the result register.
// ----------------------------------------------------------------------------
module scseg_dp #(
    parameter int MAX_FRAME = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic [scseg_pkg::SR_W-1:0]       sample_rate,
    input  logic [scseg_pkg::FL_W-1:0]       frame_len,
    input  logic [scseg_pkg::THR_W-1:0]      rms_threshold,
    input  logic [scseg_pkg::SEC_W-1:0]      min_chunk_sec,
    input  logic [scseg_pkg::SEC_W-1:0]      max_chunk_sec,
    input  logic [scseg_pkg::GAP_W-1:0]      gap_samples,
    // request payload
    input  logic                             in_cmd,
    input  logic [scseg_pkg::SMP_W-1:0]      in_sample,
    // controller link
    input  scseg_pkg::ctrl_cmd_t             cmd,
    output scseg_pkg::ctrl_stat_t            stat,
    // result channel
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [71:0]                      m_tdata,
    output logic                             m_tuser
);

    localparam int FILL_W = $clog2(MAX_FRAME);
    localparam int N_W    = $clog2(MAX_FRAME + 1);
    localparam int E_W    = scseg_pkg::SQ_W + FILL_W;
    localparam int TSQ_W  = 2 * scseg_pkg::THR_W;
    localparam int TP_W   = TSQ_W + N_W;
    localparam int CMP_W  = (E_W > TP_W) ? E_W : TP_W;
    localparam int LIM_W  = scseg_pkg::LIM_W;
    localparam int PROD_W = scseg_pkg::PROD_W;
    localparam int SIL_W  = scseg_pkg::SIL_W;
    localparam int LEN_W  = scseg_pkg::LEN_W;
    localparam int ST_W   = scseg_pkg::START_W;
    localparam int SMS_W  = scseg_pkg::START_MS_W;
    localparam int DMS_W  = scseg_pkg::DUR_MS_W;
    localparam logic [LIM_W-1:0] CHUNK_CAP =
        LIM_W'((64'd1 << LEN_W) - 64'(MAX_FRAME));

    // Request capture
    logic                         cmd_reg;
    logic [scseg_pkg::SMP_W-1:0]  mag_reg;
    logic [scseg_pkg::SMP_W-1:0]  mag;

    // Frame and chunk state
    logic [FILL_W-1:0]  fill_reg;
    logic [E_W-1:0]     energy_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [ST_W-1:0]    start_reg;
    logic [SIL_W-1:0]   silence_reg;
    logic               speech_reg;

    // Per-sample work registers
    logic [scseg_pkg::SQ_W-1:0] sq_reg;
    logic [N_W-1:0]             n_reg;
    logic [TP_W-1:0]            thr_prod_reg;

    // Configuration derived values
    logic [scseg_pkg::SR_W-1:0] rate_eff;
    logic [scseg_pkg::SR_W-1:0] rate_reg;
    logic [TSQ_W-1:0]           thr_sq_reg;
    logic [LIM_W-1:0]           max_prod;
    logic [LIM_W-1:0]           max_lim_reg;
    logic [LIM_W-1:0]           min_lim_reg;
    logic [N_W-1:0]             flen_eff;

    // Millisecond conversion
    logic [PROD_W-1:0] scale_x;
    logic [PROD_W-1:0] prod_reg;
    logic              div_done;
    logic [PROD_W-1:0] div_quo;
    logic [SMS_W-1:0]  start_ms_hold_reg;
    logic [SMS_W-1:0]  start_ms_sat;
    logic [DMS_W-1:0]  dur_ms_sat;

    // Result register
    logic              m_tvalid_reg;
    logic [SMS_W-1:0]  m_start_reg;
    logic [DMS_W-1:0]  m_dur_reg;
    logic              m_speech_reg;

    logic              speech_frame;
    logic [SIL_W:0]    sil_sum;

    // Magnitude of the Q15 sample; the most negative code maps to 0x8000
    assign mag = in_sample[scseg_pkg::SMP_W-1] ? scseg_pkg::SMP_W'(~in_sample + 1'b1)
                                               : in_sample;

    // Effective sample rate and frame length
    assign rate_eff = (sample_rate == '0) ? scseg_pkg::SR_W'(1) : sample_rate;

    always_comb begin
        if (frame_len == '0) begin
            flen_eff = N_W'(1);
        end else if (32'(frame_len) > 32'(MAX_FRAME)) begin
            flen_eff = N_W'(MAX_FRAME);
        end else begin
            flen_eff = N_W'(frame_len);
        end
    end

    assign max_prod = LIM_W'(max_chunk_sec) * LIM_W'(rate_eff);

    // Register the configuration products
    always_ff @(posedge aclk) begin
        rate_reg    <= rate_eff;
        thr_sq_reg  <= TSQ_W'(rms_threshold) * TSQ_W'(rms_threshold);
        max_lim_reg <= (max_prod > CHUNK_CAP) ? CHUNK_CAP : max_prod;
        min_lim_reg <= LIM_W'(min_chunk_sec) * LIM_W'(rate_eff);
    end

    // Frame classification and saturating silence run
    assign speech_frame = CMP_W'(energy_reg) >= CMP_W'(thr_prod_reg);
    assign sil_sum      = {1'b0, silence_reg} + (SIL_W + 1)'(n_reg);

    // Capture the request and run the per-sample steps
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            cmd_reg <= in_cmd;
            mag_reg <= mag;
        end
        if (cmd.sq_load) begin
            sq_reg <= scseg_pkg::SQ_W'(32'(mag_reg) * 32'(mag_reg));
            n_reg  <= N_W'(fill_reg) + N_W'(1);
        end
        if (cmd.acc) begin
            thr_prod_reg <= TP_W'(thr_sq_reg) * TP_W'(n_reg);
        end
    end

    // Frame and chunk state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            energy_reg  <= '0;
            len_reg     <= '0;
            start_reg   <= '0;
            silence_reg <= '0;
            speech_reg  <= 1'b0;
        end else begin
            if (cmd.acc) begin
                energy_reg <= energy_reg + E_W'(sq_reg);
                if (n_reg < flen_eff) begin
                    fill_reg <= FILL_W'(n_reg);
                end
            end
            if (cmd.frame_end) begin
                if (speech_frame) begin
                    speech_reg  <= 1'b1;
                    silence_reg <= '0;
                end else if (sil_sum[SIL_W]) begin
                    silence_reg <= '1;
                end else begin
                    silence_reg <= sil_sum[SIL_W-1:0];
                end
                len_reg    <= len_reg + LEN_W'(n_reg);
                fill_reg   <= '0;
                energy_reg <= '0;
            end
            if (cmd.flush_add) begin
                len_reg    <= len_reg + LEN_W'(fill_reg);
                fill_reg   <= '0;
                energy_reg <= '0;
            end
            if (cmd.out_load) begin
                start_reg  <= start_reg + ST_W'(len_reg);
                len_reg    <= '0;
                speech_reg <= 1'b0;
            end
        end
    end

    // Scale by 1000 as 1024 - 32 + 8 in two steps, mul_a then mul_b
    assign scale_x = cmd.sel_len ? PROD_W'(len_reg) : PROD_W'(start_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul_a) begin
            prod_reg <= (scale_x << 10) - (scale_x << 5);
        end else if (cmd.mul_b) begin
            prod_reg <= prod_reg + (scale_x << 3);
        end
    end

    scseg_div #(
        .DVD_W (PROD_W),
        .DVS_W (scseg_pkg::SR_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (rate_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Saturate the quotients at their field widths
    assign start_ms_sat = (|div_quo[PROD_W-1:SMS_W]) ? '1 : div_quo[SMS_W-1:0];
    assign dur_ms_sat   = (|div_quo[PROD_W-1:DMS_W]) ? '1 : div_quo[DMS_W-1:0];

    // Hold the start time while the duration is divided
    always_ff @(posedge aclk) begin
        if (div_done && !cmd.sel_len) begin
            start_ms_hold_reg <= start_ms_sat;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_start_reg  <= start_ms_hold_reg;
            m_dur_reg    <= dur_ms_sat;
            m_speech_reg <= speech_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_dur_reg, m_start_reg};
    assign m_tuser  = m_speech_reg;

    // Status to the controller
    always_comb begin
        stat.is_flush    = (cmd_reg == scseg_pkg::CMD_FLUSH);
        stat.frame_done  = (n_reg >= flen_eff);
        stat.chunk_empty = (len_reg == '0);
        stat.close_hit   = ({1'b0, len_reg} >= max_lim_reg) ||
                           (({1'b0, len_reg} >= min_lim_reg) && speech_reg &&
                            (silence_reg >= SIL_W'(gap_samples)));
        stat.div_done    = div_done;
        stat.out_full    = m_tvalid_reg && !m_tready;
    end

endmodule

### sv/scseg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scseg_ctrl
// Segmenter controller: sequences the sample, frame-end, flush and
// chunk-close steps of the datapath.
// ----------------------------------------------------------------------------
module scseg_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  scseg_pkg::ctrl_stat_t stat,
    output scseg_pkg::ctrl_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_STEP      = 4'd1;
    localparam logic [3:0] ST_ACC       = 4'd2;
    localparam logic [3:0] ST_DECIDE    = 4'd3;
    localparam logic [3:0] ST_CHECK     = 4'd4;
    localparam logic [3:0] ST_FLUSH_CHK = 4'd5;
    localparam logic [3:0] ST_MUL_A     = 4'd6;
    localparam logic [3:0] ST_MUL_B     = 4'd7;
    localparam logic [3:0] ST_DIV_GO    = 4'd8;
    localparam logic [3:0] ST_DIV_WAIT  = 4'd9;
    localparam logic [3:0] ST_EMIT      = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       phase_reg, phase_next;

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.sel_len = phase_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_STEP;
                end
            end
            ST_STEP: begin
                if (stat.is_flush) begin
                    cmd.flush_add = 1'b1;
                    state_next    = ST_FLUSH_CHK;
                end else begin
                    cmd.sq_load = 1'b1;
                    state_next  = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = stat.frame_done ? ST_DECIDE : ST_IDLE;
            end
            ST_DECIDE: begin
                cmd.frame_end = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK: begin
                phase_next = 1'b0;
                state_next = stat.close_hit ? ST_MUL_A : ST_IDLE;
            end
            ST_FLUSH_CHK: begin
                phase_next = 1'b0;
                state_next = stat.chunk_empty ? ST_IDLE : ST_MUL_A;
            end
            ST_MUL_A: begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.mul_b  = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                // Start time first, then duration
                if (stat.div_done) begin
                    if (phase_reg) begin
                        state_next = ST_EMIT;
                    end else begin
                        phase_next = 1'b1;
                        state_next = ST_MUL_A;
                    end
                end
            end
            ST_EMIT: begin
                // Hold until the result register is free
                if (!stat.out_full) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

### sv/speech_chunk_segmenter_core.sv
`timescale 1ns / 1ps
// A sample passes the idle, step and accumulate states; a frame end adds the decide and
// check states; a flush passes idle, step and flush check. A close runs two passes
// (times-1000 scaling, divider start, divider steps, done), start time then duration,
// then loads the free result register. A new request is taken only once the last is done.
// The result waits in an output register; the next request is taken meanwhile.
// Reset (aresetn low, synchronous) restores register defaults and clears all chunk state.
// ----------------------------------------------------------------------------
// speech_chunk_segmenter_core
// Energy-based voice activity segmentation of Q15 audio into chunks with
// start time, duration and a speech flag.
// ----------------------------------------------------------------------------
module speech_chunk_segmenter_core #(
    parameter int MAX_FRAME = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [scseg_pkg::ADDR_W-1:0]    paddr,
    input  logic [scseg_pkg::DATA_W-1:0]    pwdata,
    output logic [scseg_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,
    // sample channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] sample
    input  logic                            s_tuser,   // [0] cmd
    // chunk channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [71:0]                     m_tdata,   // [45:0] start_ms, [69:46] duration_ms
    output logic                            m_tuser    // [0] had_speech
);

    logic [scseg_pkg::SR_W-1:0]  sample_rate_reg;
    logic [scseg_pkg::FL_W-1:0]  frame_len_reg;
    logic [scseg_pkg::THR_W-1:0] rms_threshold_reg;
    logic [scseg_pkg::SEC_W-1:0] min_chunk_sec_reg;
    logic [scseg_pkg::SEC_W-1:0] max_chunk_sec_reg;
    logic [scseg_pkg::GAP_W-1:0] gap_samples_reg;

    logic [scseg_pkg::IDX_W-1:0] reg_idx;
    logic                        wr_en;

    scseg_pkg::ctrl_cmd_t  cmd;
    scseg_pkg::ctrl_stat_t stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[scseg_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_rate_reg   <= scseg_pkg::RST_SAMPLE_RATE;
            frame_len_reg     <= scseg_pkg::RST_FRAME_LEN;
            rms_threshold_reg <= scseg_pkg::RST_RMS_THRESHOLD;
            min_chunk_sec_reg <= scseg_pkg::RST_MIN_CHUNK_SEC;
            max_chunk_sec_reg <= scseg_pkg::RST_MAX_CHUNK_SEC;
            gap_samples_reg   <= scseg_pkg::RST_GAP_SAMPLES;
        end else if (wr_en) begin
            case (reg_idx)
                scseg_pkg::REG_SAMPLE_RATE:
                    sample_rate_reg <= pwdata[scseg_pkg::SR_W-1:0];
                scseg_pkg::REG_FRAME_LEN:
                    frame_len_reg <= pwdata[scseg_pkg::FL_W-1:0];
                scseg_pkg::REG_RMS_THRESHOLD:
                    rms_threshold_reg <= pwdata[scseg_pkg::THR_W-1:0];
                scseg_pkg::REG_MIN_CHUNK_SEC:
                    min_chunk_sec_reg <= pwdata[scseg_pkg::SEC_W-1:0];
                scseg_pkg::REG_MAX_CHUNK_SEC:
                    max_chunk_sec_reg <= pwdata[scseg_pkg::SEC_W-1:0];
                scseg_pkg::REG_GAP_SAMPLES:
                    gap_samples_reg <= pwdata[scseg_pkg::GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            scseg_pkg::REG_SAMPLE_RATE:   prdata = scseg_pkg::DATA_W'(sample_rate_reg);
            scseg_pkg::REG_FRAME_LEN:     prdata = scseg_pkg::DATA_W'(frame_len_reg);
            scseg_pkg::REG_RMS_THRESHOLD: prdata = scseg_pkg::DATA_W'(rms_threshold_reg);
            scseg_pkg::REG_MIN_CHUNK_SEC: prdata = scseg_pkg::DATA_W'(min_chunk_sec_reg);
            scseg_pkg::REG_MAX_CHUNK_SEC: prdata = scseg_pkg::DATA_W'(max_chunk_sec_reg);
            scseg_pkg::REG_GAP_SAMPLES:   prdata = scseg_pkg::DATA_W'(gap_samples_reg);
            default:                      prdata = '0;
        endcase
    end

    scseg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scseg_dp #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .sample_rate   (sample_rate_reg),
        .frame_len     (frame_len_reg),
        .rms_threshold (rms_threshold_reg),
        .min_chunk_sec (min_chunk_sec_reg),
        .max_chunk_sec (max_chunk_sec_reg),
        .gap_samples   (gap_samples_reg),
        .in_cmd        (s_tuser),
        .in_sample     (s_tdata),
        .cmd           (cmd),
        .stat          (stat),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the speech chunk segmenter. A scoreboard class keeps
// its own copy of the registers and the frame and chunk state, predicts every
// closed chunk from the accepted sample requests and compares each result
// request field by field. Directed requests cover the field extremes and the
// corner cases; shaped random bursts of loud, quiet and noisy audio with
// flushes run under many register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_FRAME   = 4096;
    localparam int STALL_LIMIT = 5000;
    localparam longint unsigned START_MS_MAX = (64'd1 << scseg_pkg::START_MS_W) - 1;
    localparam longint unsigned DUR_MS_MAX   = (64'd1 << scseg_pkg::DUR_MS_W) - 1;
    localparam longint unsigned CHUNK_CAP    = (64'd1 << scseg_pkg::LEN_W) - MAX_FRAME;

    typedef struct packed {
        logic [scseg_pkg::START_MS_W-1:0] start_ms;
        logic [scseg_pkg::DUR_MS_W-1:0]   dur_ms;
        logic                             had_speech;
    } chunk_t;

    // ------------------------------------------------------------------------
    // Chunk predictor and checker
    // ------------------------------------------------------------------------
    class chunk_scoreboard;
        logic [scseg_pkg::SR_W-1:0]  rate;
        logic [scseg_pkg::FL_W-1:0]  flen;
        logic [scseg_pkg::THR_W-1:0] thr;
        logic [scseg_pkg::SEC_W-1:0] min_sec;
        logic [scseg_pkg::SEC_W-1:0] max_sec;
        logic [scseg_pkg::GAP_W-1:0] gap;

        logic [11:0]                   fill;
        longint unsigned               energy;
        logic [scseg_pkg::LEN_W-1:0]   clen;
        logic [scseg_pkg::START_W-1:0] cstart;
        logic [scseg_pkg::SIL_W-1:0]   silence;
        logic                          speech;

        chunk_t pending[$];
        int     errors;

        function new();
            rate    = scseg_pkg::RST_SAMPLE_RATE;
            flen    = scseg_pkg::RST_FRAME_LEN;
            thr     = scseg_pkg::RST_RMS_THRESHOLD;
            min_sec = scseg_pkg::RST_MIN_CHUNK_SEC;
            max_sec = scseg_pkg::RST_MAX_CHUNK_SEC;
            gap     = scseg_pkg::RST_GAP_SAMPLES;
            fill    = '0;
            energy  = 0;
            clen    = '0;
            cstart  = '0;
            silence = '0;
            speech  = 1'b0;
            errors  = 0;
        endfunction

        function void write_reg(logic [scseg_pkg::IDX_W-1:0] idx,
                                logic [scseg_pkg::DATA_W-1:0] val);
            case (idx)
                scseg_pkg::REG_SAMPLE_RATE:   rate    = val[scseg_pkg::SR_W-1:0];
                scseg_pkg::REG_FRAME_LEN:     flen    = val[scseg_pkg::FL_W-1:0];
                scseg_pkg::REG_RMS_THRESHOLD: thr     = val[scseg_pkg::THR_W-1:0];
                scseg_pkg::REG_MIN_CHUNK_SEC: min_sec = val[scseg_pkg::SEC_W-1:0];
                scseg_pkg::REG_MAX_CHUNK_SEC: max_sec = val[scseg_pkg::SEC_W-1:0];
                scseg_pkg::REG_GAP_SAMPLES:   gap     = val[scseg_pkg::GAP_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned eff_rate();
            return (rate == 0) ? 64'd1 : 64'(rate);
        endfunction

        // Convert a sample count to milliseconds, truncated and saturated
        function longint unsigned to_millis(longint unsigned count, longint unsigned cap);
            longint unsigned ms;
            ms = count * 1000 / eff_rate();
            return (ms > cap) ? cap : ms;
        endfunction

        function void close_chunk();
            chunk_t c;
            c.start_ms   = scseg_pkg::START_MS_W'(to_millis(64'(cstart), START_MS_MAX));
            c.dur_ms     = scseg_pkg::DUR_MS_W'(to_millis(64'(clen), DUR_MS_MAX));
            c.had_speech = speech;
            pending.push_back(c);
            cstart = cstart + scseg_pkg::START_W'(clen);
            clen   = '0;
            speech = 1'b0;
        endfunction

        // Advance the segmentation state by one accepted request
        function void note_input(logic cmd, logic [scseg_pkg::SMP_W-1:0] smp);
            longint unsigned raw, mag, n, fl, lim, max_s, min_s, run;
            if (cmd == scseg_pkg::CMD_FLUSH) begin
                clen   = clen + scseg_pkg::LEN_W'(fill);
                fill   = '0;
                energy = 0;
                if (clen != 0)
                    close_chunk();
                return;
            end
            raw    = 64'(smp);
            mag    = smp[scseg_pkg::SMP_W-1] ? (64'h10000 - raw) : raw;
            energy = energy + mag * mag;
            n      = 64'(fill) + 1;
            fl     = (flen == 0) ? 64'd1 : 64'(flen);
            if (fl > MAX_FRAME)
                fl = MAX_FRAME;
            if (n < fl) begin
                fill = 12'(n);
                return;
            end
            // Frame end: classify, then fold into the chunk
            lim = 64'(thr) * 64'(thr) * n;
            if (energy >= lim) begin
                speech  = 1'b1;
                silence = '0;
            end else begin
                run     = 64'(silence) + n;
                silence = (run > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(run);
            end
            clen   = clen + scseg_pkg::LEN_W'(n);
            fill   = '0;
            energy = 0;
            max_s  = 64'(max_sec) * eff_rate();
            if (max_s > CHUNK_CAP)
                max_s = CHUNK_CAP;
            min_s = 64'(min_sec) * eff_rate();
            if (64'(clen) >= max_s)
                close_chunk();
            else if (64'(clen) >= min_s && speech && silence >= 32'(gap))
                close_chunk();
        endfunction

        function void flag(string what, longint unsigned want, longint unsigned got);
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0d, got %0d", what, want, got);
        endfunction

        // Compare one result request with the oldest predicted chunk
        function void check_result(logic [71:0] data, logic user);
            chunk_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected chunk: start_ms %0d duration_ms %0d had_speech %0b",
                             data[45:0], data[69:46], user);
                return;
            end
            want = pending.pop_front();
            if (data[45:0] !== want.start_ms)
                flag("start_ms", want.start_ms, data[45:0]);
            if (data[69:46] !== want.dur_ms)
                flag("duration_ms", want.dur_ms, data[69:46]);
            if (user !== want.had_speech)
                flag("had_speech", want.had_speech, user);
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [scseg_pkg::ADDR_W-1:0] paddr;
    logic [scseg_pkg::DATA_W-1:0] pwdata;
    logic [scseg_pkg::DATA_W-1:0] prdata;
    logic                         pready;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [15:0]                  s_tdata;
    logic                         s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [71:0]                  m_tdata;
    logic                         m_tuser;

    chunk_scoreboard sb;
    logic            calm;
    logic            hold_req;
    int              stall_cycles;

    speech_chunk_segmenter_core #(
        .MAX_FRAME (MAX_FRAME)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // End the run when neither channel moves a request for too long
    initial stall_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Chunk receiver: check accepted results, idle at random, hold off on request
    initial begin : sink
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 14);
            end
        end
    end

    // Register write: setup phase, access phase, then the bus idles
    task automatic apb_write(input logic [scseg_pkg::IDX_W-1:0] idx,
                             input logic [scseg_pkg::DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // Offer one request, idling at random first; returns once accepted
    task automatic send_item(input logic cmd, input logic [15:0] smp);
        while (!calm && $urandom_range(0, 99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, smp);
    endtask

    // Stop sending, wait for all predicted chunks, then let the block settle
    task automatic settle_chunks();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic configure(input logic [scseg_pkg::SR_W-1:0] sr,
                             input logic [scseg_pkg::FL_W-1:0] fl,
                             input logic [scseg_pkg::THR_W-1:0] th,
                             input logic [scseg_pkg::SEC_W-1:0] mn,
                             input logic [scseg_pkg::SEC_W-1:0] mx,
                             input logic [scseg_pkg::GAP_W-1:0] gp);
        settle_chunks();
        apb_write(scseg_pkg::REG_SAMPLE_RATE, 32'(sr));
        apb_write(scseg_pkg::REG_FRAME_LEN, 32'(fl));
        apb_write(scseg_pkg::REG_RMS_THRESHOLD, 32'(th));
        apb_write(scseg_pkg::REG_MIN_CHUNK_SEC, 32'(mn));
        apb_write(scseg_pkg::REG_MAX_CHUNK_SEC, 32'(mx));
        apb_write(scseg_pkg::REG_GAP_SAMPLES, 32'(gp));
    endtask

    // Random audio as bursts of loud, quiet and noisy samples with flushes
    task automatic play_audio(input int count, input int level);
        int left, run, kind, mag, i;
        logic [15:0] smp;
        left = count;
        while (left > 0) begin
            kind = $urandom_range(0, 11);
            if (kind == 0) begin
                send_item(scseg_pkg::CMD_FLUSH, 16'($urandom));
                left--;
            end else begin
                run = $urandom_range(1, 24);
                if (run > left)
                    run = left;
                for (i = 0; i < run; i++) begin
                    if (kind <= 5)
                        mag = $urandom_range(level, 32767);
                    else if (kind <= 9)
                        mag = $urandom_range(0, level / 2);
                    else
                        mag = -1;
                    if (mag < 0)
                        smp = 16'($urandom);
                    else if ($urandom_range(0, 1) != 0)
                        smp = 16'(-mag);
                    else
                        smp = 16'(mag);
                    send_item(scseg_pkg::CMD_SAMPLE, smp);
                end
                left = left - run;
            end
        end
    endtask

    initial begin : stimulus
        int ph, i;
        logic [scseg_pkg::SR_W-1:0]  sr;
        logic [scseg_pkg::FL_W-1:0]  fl;
        logic [scseg_pkg::THR_W-1:0] th;
        logic [scseg_pkg::SEC_W-1:0] mn;
        logic [scseg_pkg::SEC_W-1:0] mx;
        logic [scseg_pkg::GAP_W-1:0] gp;

        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tuser  = scseg_pkg::CMD_SAMPLE;
        s_tdata  = '0;
        calm     = 1'b0;
        hold_req = 1'b0;
        sb       = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty flush after reset, partial frame flushed, empty flush again
        send_item(scseg_pkg::CMD_FLUSH, 16'h0000);
        send_item(scseg_pkg::CMD_SAMPLE, 16'h7FFF);
        send_item(scseg_pkg::CMD_SAMPLE, 16'h8000);
        send_item(scseg_pkg::CMD_SAMPLE, 16'h0000);
        send_item(scseg_pkg::CMD_FLUSH, 16'hFFFF);
        send_item(scseg_pkg::CMD_FLUSH, 16'h1234);

        // One-sample frames at full threshold: equal energy counts as speech
        configure(18'd1, 13'd1, 15'h7FFF, 10'd0, 10'h3FF, 27'd0);
        send_item(scseg_pkg::CMD_SAMPLE, 16'h8000);
        send_item(scseg_pkg::CMD_SAMPLE, 16'h7FFF);
        send_item(scseg_pkg::CMD_SAMPLE, 16'h7FFE);
        send_item(scseg_pkg::CMD_SAMPLE, 16'h0000);
        send_item(scseg_pkg::CMD_SAMPLE, 16'h0001);
        send_item(scseg_pkg::CMD_FLUSH, 16'hFFFF);

        // Zero rate, zero frame length, zero threshold: every sample closes
        configure(18'd0, 13'd0, 15'd0, 10'd0, 10'd1, 27'd0);
        send_item(scseg_pkg::CMD_SAMPLE, 16'h5555);
        send_item(scseg_pkg::CMD_SAMPLE, 16'hAAAA);
        send_item(scseg_pkg::CMD_SAMPLE, 16'h0000);

        // Short frames, then shrink the frame length with a frame open
        configure(18'd2, 13'd4, 15'd100, 10'd1, 10'd5, 27'd4);
        for (i = 0; i < 6; i++)
            send_item(scseg_pkg::CMD_SAMPLE, (i < 4) ? 16'h0400 : 16'h0003);
        configure(18'd2, 13'd1, 15'd100, 10'd1, 10'd5, 27'd4);
        send_item(scseg_pkg::CMD_SAMPLE, 16'h0002);
        send_item(scseg_pkg::CMD_FLUSH, 16'h0000);

        // Random phases, each with its own register setting
        for (ph = 0; ph < 10; ph++) begin
            sr = 18'($urandom_range(1, 40));
            fl = 13'($urandom_range(1, 12));
            th = 15'($urandom_range(100, 4000));
            mn = 10'($urandom_range(0, 3));
            mx = 10'($urandom_range(1, 10));
            gp = 27'($urandom_range(0, 4 * fl));
            case (ph)
                0: sr = '0;
                1: begin
                    mx = '0;
                    fl = 13'($urandom_range(1, 3));
                end
                2: th = 15'h7FFF;
                3: begin
                    gp = 27'h7FF_FFFF;
                    mn = '0;
                end
                4: begin
                    sr = 18'h3FFFF;
                    mn = 10'h3FF;
                    mx = 10'h3FF;
                end
                5: begin
                    fl = '0;
                    th = '0;
                end
                6: begin
                    mn = '0;
                    gp = '0;
                end
                9: mx = 10'h3FF;
                default: ;
            endcase

            // Frame length above the limit, left open so the next setting cuts it short
            if (ph == 7) begin
                configure(18'd1, 13'h1FFF, 15'h7FFF, 10'd0, 10'd1, 27'd0);
                for (i = 0; i < 250; i++)
                    send_item(scseg_pkg::CMD_SAMPLE, 16'h8000);
                for (i = 0; i < 50; i++)
                    send_item(scseg_pkg::CMD_SAMPLE, 16'($urandom));
            end

            configure(sr, fl, th, mn, mx, gp);
            if (ph == 1)
                hold_req = 1'b1;
            if (ph == 8)
                calm = 1'b1;
            play_audio(100, int'(th));
            calm = 1'b0;
            if ($urandom_range(0, 1) != 0)
                send_item(scseg_pkg::CMD_FLUSH, 16'($urandom));
        end

        // Drain and report
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### filelist.f
sv/scseg_pkg.sv
sv/scseg_div.sv
sv/scseg_dp.sv
sv/scseg_ctrl.sv
sv/speech_chunk_segmenter_core.sv
bench/tb_top.sv
